// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/uer_pkg.sv =====
// Shared types, codes and constants of the ultrasonic echo-ranging block.
package uer_pkg;

    localparam int NUM_SLOTS_DEF = 4;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    localparam logic [15:0] MIN_DUR_RST = 16'd116;
    localparam logic [15:0] MAX_DUR_RST = 16'd23529;
    localparam logic [2:0]  AVG_CNT_RST = 3'd4;

    // floor(w * 17 / 1000) == (w * SCALE_MUL) >> SCALE_SHIFT for every 16-bit w
    localparam logic [25:0] SCALE_MUL   = 26'd36507228;
    localparam int          SCALE_SHIFT = 31;
    localparam int          PROD_W      = 42;
    localparam int          QUOT_W      = PROD_W - SCALE_SHIFT;

    // quotient saturates at 255, so eight restoring steps are enough
    localparam int DIV_STEPS = 8;

    typedef enum logic [1:0] {
        KIND_EDGE,
        KIND_TRIGGER,
        KIND_CHECK,
        KIND_READ
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_DATA,
        ST_SHORT,
        ST_REFUSED
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_DUR,
        CFG_MAX_DUR,
        CFG_AVG_CNT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_AVG,
        TOP_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        AVG_IDLE,
        AVG_SCAN,
        AVG_SAT,
        AVG_DIV
    } avg_state_t;

    typedef struct packed {
        logic [15:0] min_dur;
        logic [15:0] max_dur;
        logic [2:0]  avg_cnt;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        fire;
        logic [7:0]  failed;
        logic [31:0] latest;
    } res_t;

    typedef struct packed {
        logic [7:0]  failed;
        logic [31:0] latest;
    } evt_state_t;

    typedef struct packed {
        logic       done;
        logic [7:0] distance;
    } avg_res_t;

endpackage

// ===== design/uer_event.sv =====
// Echo, trigger and check event handling with the width slot store.
module uer_event #(
    parameter int NUM_SLOTS = uer_pkg::NUM_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               evt_en,
    input  uer_pkg::kind_t                     kind,
    input  logic                               echo_level,
    input  logic [31:0]                        time_us,
    input  logic [1:0]                         slot_index,
    input  uer_pkg::cfg_t                      cfg,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]     rd_idx,
    output logic [15:0]                        rd_data,
    output uer_pkg::res_t                      res_o,
    output uer_pkg::evt_state_t                state_o
);
    import uer_pkg::*;

    logic [31:0] start_reg, start_next;
    logic [31:0] latest_reg, latest_next;
    logic        flag_reg, flag_next;
    logic [7:0]  refusal_reg, refusal_next;
    logic [15:0] slots_reg [NUM_SLOTS];

    logic        slot_we;
    logic [31:0] clamped;
    status_t     status;
    logic        fire;

    always_comb begin
        start_next   = start_reg;
        latest_next  = latest_reg;
        flag_next    = flag_reg;
        refusal_next = refusal_reg;
        slot_we      = 1'b0;
        status       = ST_OK;
        fire         = 1'b0;
        clamped      = (latest_reg > {16'b0, cfg.max_dur}) ? {16'b0, cfg.max_dur} : latest_reg;
        unique case (kind)
            KIND_EDGE: begin
                if (echo_level) begin
                    start_next = time_us;
                end else begin
                    latest_next = time_us - start_reg;
                    flag_next   = 1'b1;
                end
            end
            KIND_TRIGGER: begin
                if (echo_level) begin
                    if (refusal_reg != 8'hFF) begin
                        refusal_next = refusal_reg + 8'd1;
                    end
                    status = ST_REFUSED;
                end else begin
                    refusal_next = 8'd0;
                    fire         = 1'b1;
                end
            end
            KIND_CHECK: begin
                if (!flag_reg) begin
                    status = ST_NO_DATA;
                end else begin
                    flag_next = 1'b0;
                    // discard test comes before the clamp
                    if (latest_reg < {16'b0, cfg.min_dur}) begin
                        status = ST_SHORT;
                    end else begin
                        latest_next = clamped;
                        slot_we     = (int'(slot_index) < NUM_SLOTS);
                    end
                end
            end
            KIND_READ: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            latest_reg  <= {16'b0, MAX_DUR_RST};
            flag_reg    <= 1'b0;
            refusal_reg <= '0;
        end else if (evt_en) begin
            start_reg   <= start_next;
            latest_reg  <= latest_next;
            flag_reg    <= flag_next;
            refusal_reg <= refusal_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slots_reg[i] <= MAX_DUR_RST;
            end
        end else if (evt_en && slot_we) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (int'(slot_index) == i) begin
                    slots_reg[i] <= clamped[15:0];
                end
            end
        end
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (int'(rd_idx) == i) begin
                rd_data = slots_reg[i];
            end
        end
    end

    assign res_o.status   = status;
    assign res_o.fire     = fire;
    assign res_o.failed   = refusal_next;
    assign res_o.latest   = latest_next;
    assign state_o.failed = refusal_reg;
    assign state_o.latest = latest_reg;

endmodule

// ===== design/uer_avg.sv =====
// Distance averaging sequencer: per-slot scaling multiplier and bit-serial divider.
module uer_avg #(
    parameter int NUM_SLOTS = uer_pkg::NUM_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [2:0]                         avg_cnt,
    output logic [$clog2(NUM_SLOTS+1)-1:0]     rd_idx,
    input  logic [15:0]                        rd_data,
    output uer_pkg::avg_res_t                  res_o
);
    import uer_pkg::*;

    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W  = QUOT_W + CNT_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    avg_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [QUOT_W-1:0]    q_reg, q_next;
    logic                 qv_reg, qv_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIV_STEPS-1:0] shift_reg, shift_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [7:0]           dist_reg, dist_next;
    logic                 done_reg, done_next;

    logic [PROD_W-1:0]    prod;
    logic [CNT_W:0]       trial;
    logic                 qbit;
    logic [CNT_W-1:0]     n_clamp;

    assign prod    = {{(PROD_W-16){1'b0}}, rd_data} * {{(PROD_W-26){1'b0}}, SCALE_MUL};
    assign n_clamp = (int'(avg_cnt) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS) : CNT_W'(avg_cnt);
    assign trial   = {rem_reg, shift_reg[DIV_STEPS-1]};
    assign qbit    = (trial >= {1'b0, cnt_reg});

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        qv_next    = qv_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        step_next  = step_reg;
        dist_next  = dist_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            AVG_IDLE: begin
                if (start) begin
                    idx_next   = '0;
                    n_next     = n_clamp;
                    qv_next    = 1'b0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = AVG_SCAN;
                end
            end
            AVG_SCAN: begin
                // accumulate the width scaled last cycle, scale the next one
                if (qv_reg) begin
                    sum_next = sum_reg + SUM_W'(q_reg);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (idx_reg < n_reg) begin
                    q_next   = prod[PROD_W-1:SCALE_SHIFT];
                    qv_next  = (rd_data != 16'd0);
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    qv_next    = 1'b0;
                    state_next = AVG_SAT;
                end
            end
            AVG_SAT: begin
                if (cnt_reg == '0) begin
                    dist_next  = 8'd0;
                    done_next  = 1'b1;
                    state_next = AVG_IDLE;
                end else if (sum_reg >= SUM_W'({cnt_reg, 8'b0})) begin
                    dist_next  = 8'hFF;
                    done_next  = 1'b1;
                    state_next = AVG_IDLE;
                end else begin
                    // upper part is below the divisor, start from it
                    rem_next   = CNT_W'(sum_reg >> DIV_STEPS);
                    shift_next = sum_reg[DIV_STEPS-1:0];
                    step_next  = '0;
                    state_next = AVG_DIV;
                end
            end
            AVG_DIV: begin
                rem_next   = qbit ? CNT_W'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
                shift_next = {shift_reg[DIV_STEPS-2:0], qbit};
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    dist_next  = {shift_reg[DIV_STEPS-2:0], qbit};
                    done_next  = 1'b1;
                    state_next = AVG_IDLE;
                end
            end
            default: begin
                state_next = AVG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AVG_IDLE;
            done_reg  <= 1'b0;
            qv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            qv_reg    <= qv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        q_reg     <= q_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        step_reg  <= step_next;
        dist_reg  <= dist_next;
    end

    assign rd_idx         = idx_reg;
    assign res_o.done     = done_reg;
    assign res_o.distance = dist_reg;

endmodule

// ===== design/ultrasonic_echo_ranging.sv =====
// Top level of the ultrasonic echo-ranging front end.
//
//   channel   direction   transfer on            contents
//   s_*       in          s_tvalid & s_tready    one event
//   m_*       out         m_tvalid & m_tready    one result per event
//   cfg_*     in          cfg_wr_en              register write
//
// The result of an edge, trigger or check event sits in the output register the
// next cycle, and a new event can be taken in the same cycle.
// A read scans min(average_count, NUM_SLOTS) slots, one multiplier pass per
// slot, then runs an eight-step one-bit-per-cycle divider that is skipped when
// no slot is valid or the average saturates. s_tready is low during the read.
// Reset is synchronous, active low, and restores the configuration register defaults.
// A stalled m_tready holds the result and blocks the next transfer only when
// the output register is still full.
module ultrasonic_echo_ranging #(
    parameter int NUM_SLOTS = uer_pkg::NUM_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] echo_level, [32:1] time_us, [34:33] slot_index, [39:35] zero
    input  logic [uer_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] fire_trigger, [8:1] failed_count, [16:9] distance_cm,
    // [48:17] latest_width, [55:49] zero
    output logic [uer_pkg::M_DATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_addr,
    input  logic [15:0]                    cfg_wdata
);
    import uer_pkg::*;

    cfg_t                           cfg_reg;
    top_state_t                     state_reg, state_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]            m_tdata_reg, m_tdata_next;
    logic [1:0]                     m_tuser_reg, m_tuser_next;

    kind_t                          kind;
    logic                           out_free;
    logic                           accept;
    logic                           is_read;
    logic                           evt_en;
    logic                           avg_start;
    logic [$clog2(NUM_SLOTS+1)-1:0] rd_idx;
    logic [15:0]                    rd_data;
    res_t                           evt_res;
    evt_state_t                     evt_state;
    avg_res_t                       avg_res;

    assign kind      = kind_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == TOP_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign is_read   = (kind == KIND_READ);
    assign evt_en    = accept && !is_read;
    assign avg_start = accept && is_read;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_dur <= MIN_DUR_RST;
            cfg_reg.max_dur <= MAX_DUR_RST;
            cfg_reg.avg_cnt <= AVG_CNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MIN_DUR: cfg_reg.min_dur <= cfg_wdata;
                CFG_MAX_DUR: cfg_reg.max_dur <= cfg_wdata;
                CFG_AVG_CNT: cfg_reg.avg_cnt <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    uer_event #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_event (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_en    (evt_en),
        .kind      (kind),
        .echo_level(s_tdata[0]),
        .time_us   (s_tdata[32:1]),
        .slot_index(s_tdata[34:33]),
        .cfg       (cfg_reg),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .res_o     (evt_res),
        .state_o   (evt_state)
    );

    uer_avg #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_avg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (avg_start),
        .avg_cnt(cfg_reg.avg_cnt),
        .rd_idx (rd_idx),
        .rd_data(rd_data),
        .res_o  (avg_res)
    );

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (state_reg)
            TOP_IDLE: begin
                if (accept) begin
                    if (is_read) begin
                        state_next = TOP_AVG;
                    end else begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = evt_res.status;
                        m_tdata_next  = {7'b0, evt_res.latest, 8'd0, evt_res.failed,
                                         evt_res.fire};
                    end
                end
            end
            TOP_AVG, TOP_HOLD: begin
                // hold the averaged result until the output register frees up
                if ((state_reg == TOP_HOLD) || avg_res.done) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = ST_OK;
                        m_tdata_next  = {7'b0, evt_state.latest, avg_res.distance,
                                         evt_state.failed, 1'b0};
                        state_next    = TOP_IDLE;
                    end else begin
                        state_next = TOP_HOLD;
                    end
                end
            end
            default: begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= TOP_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== design/uer_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`include "assert_macros.svh"

module uer_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [uer_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import uer_pkg::*;

    // a stalled result holds
    `ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `ASSERT_CLK(a_rst_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a fired trigger clears the refusal count
    `ASSERT_RST(a_fire, aclk, aresetn, m_tvalid && m_tdata[0] |-> (m_tuser == ST_OK) && (m_tdata[8:1] == 8'd0), "fire with refusals")

    // a refusal always leaves a nonzero count
    `ASSERT_RST(a_refuse, aclk, aresetn, m_tvalid && (m_tuser == ST_REFUSED) |-> (m_tdata[8:1] != 8'd0), "refusal not counted")

    // only a read result carries a distance
    `ASSERT_RST(a_dist, aclk, aresetn, m_tvalid && (m_tdata[16:9] != 8'd0) |-> (m_tuser == ST_OK) && !m_tdata[0], "distance on non-read")

endmodule

bind ultrasonic_echo_ranging uer_checker u_checker (.*);

// ===== verif/tb_ultrasonic_echo_ranging.sv =====
// Self-checking testbench for the ultrasonic echo-ranging front end.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranging;
    import uer_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        kind_t       kind;
        logic        level;
        logic [31:0] time_us;
        logic [1:0]  slot;
    } echo_event_t;

    typedef struct packed {
        status_t     status;
        logic        fire;
        logic [7:0]  failed;
        logic [7:0]  distance;
        logic [31:0] latest;
    } range_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    ultrasonic_echo_ranging u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Predictor copy of registers and state
    logic [15:0] min_dur;
    logic [15:0] max_dur;
    logic [2:0]  avg_cnt;
    logic [31:0] start_us;
    logic [31:0] pulse_us;
    logic        pulse_new;
    logic [7:0]  refusals;
    logic [15:0] slot_width [NUM_SLOTS_DEF];

    echo_event_t   event_q [$];
    range_result_t result_q [$];
    echo_event_t   cur_event;

    int  events_in     = 0;
    int  results_out   = 0;
    int  err_count     = 0;
    int  settings_used = 1;
    int  long_hold_mark = -1;
    int  send_gap      = 0;
    int  hold_left     = 0;
    int  stall_left    = 0;
    int  idle_cycles   = 0;
    bit  quiet         = 1'b0;

    range_result_t want_r;
    range_result_t got_r;

    task automatic reset_predictor();
        min_dur   = MIN_DUR_RST;
        max_dur   = MAX_DUR_RST;
        avg_cnt   = AVG_CNT_RST;
        start_us  = '0;
        pulse_us  = {16'd0, MAX_DUR_RST};
        pulse_new = 1'b0;
        refusals  = '0;
        for (int i = 0; i < NUM_SLOTS_DEF; i++) slot_width[i] = MAX_DUR_RST;
    endtask

    function automatic logic [7:0] average_cm();
        int unsigned n;
        int unsigned sum;
        int unsigned cnt;
        int unsigned avg;
        n   = (avg_cnt > 3'(NUM_SLOTS_DEF)) ? NUM_SLOTS_DEF : avg_cnt;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            if (slot_width[i] != 16'd0) begin
                cnt++;
                sum += (32'(slot_width[i]) * 17) / 1000;
            end
        end
        if (cnt == 0) return 8'd0;
        avg = sum / cnt;
        return (avg > 255) ? 8'd255 : avg[7:0];
    endfunction

    // Advance the predictor by one event and queue its result
    task automatic predict_range(input echo_event_t ev);
        range_result_t r;
        r.status   = ST_OK;
        r.fire     = 1'b0;
        r.distance = 8'd0;
        case (ev.kind)
            KIND_EDGE: begin
                if (ev.level) begin
                    start_us = ev.time_us;
                end else begin
                    pulse_us  = ev.time_us - start_us;
                    pulse_new = 1'b1;
                end
            end
            KIND_TRIGGER: begin
                if (ev.level) begin
                    if (refusals != 8'hFF) refusals++;
                    r.status = ST_REFUSED;
                end else begin
                    refusals = '0;
                    r.fire   = 1'b1;
                end
            end
            KIND_CHECK: begin
                if (!pulse_new) begin
                    r.status = ST_NO_DATA;
                end else begin
                    pulse_new = 1'b0;
                    if (pulse_us < {16'd0, min_dur}) begin
                        r.status = ST_SHORT;
                    end else begin
                        if (pulse_us > {16'd0, max_dur}) pulse_us = {16'd0, max_dur};
                        if (ev.slot < NUM_SLOTS_DEF) slot_width[ev.slot] = pulse_us[15:0];
                    end
                end
            end
            default: begin
                r.distance = average_cm();
            end
        endcase
        r.failed = refusals;
        r.latest = pulse_us;
        result_q.push_back(r);
    endtask

    // Sender: hold each item until its transfer, then maybe insert a gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_range(cur_event);
                events_in++;
                if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    cur_event = event_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, cur_event.slot, cur_event.time_us, cur_event.level};
                    s_tuser  <= cur_event.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each result transfer, stall in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_r.status   = status_t'(m_tuser);
                got_r.fire     = m_tdata[0];
                got_r.failed   = m_tdata[8:1];
                got_r.distance = m_tdata[16:9];
                got_r.latest   = m_tdata[48:17];
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d fire=%0d failed=%0d dist=%0d width=%0d",
                             $realtime, got_r.status, got_r.fire, got_r.failed, got_r.distance,
                             got_r.latest);
                    err_count++;
                end else begin
                    want_r = result_q.pop_front();
                    if (got_r !== want_r) begin
                        $display("%0t: mismatch expected status=%0d fire=%0d failed=%0d dist=%0d width=%0d",
                                 $realtime, want_r.status, want_r.fire, want_r.failed,
                                 want_r.distance, want_r.latest);
                        $display("%0t:          actual status=%0d fire=%0d failed=%0d dist=%0d width=%0d",
                                 $realtime, got_r.status, got_r.fire, got_r.failed,
                                 got_r.distance, got_r.latest);
                        err_count++;
                    end
                end
                results_out++;
            end
            if (results_out == long_hold_mark) begin
                hold_left      = LONG_HOLD;
                long_hold_mark = -1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_event(input kind_t k, input logic lvl, input logic [31:0] t,
                              input logic [1:0] s);
        echo_event_t ev;
        ev.kind    = k;
        ev.level   = lvl;
        ev.time_us = t;
        ev.slot    = s;
        event_q.push_back(ev);
    endtask

    task automatic push_pulse(input logic [31:0] t0, input logic [31:0] w);
        push_event(KIND_EDGE, 1'b1, t0, 2'($urandom));
        push_event(KIND_EDGE, 1'b0, t0 + w, 2'($urandom));
    endtask

    // Wait until the block is empty and has settled; ends on a falling edge
    task automatic wait_idle();
        while (event_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MIN_DUR: min_dur = val;
            CFG_MAX_DUR: max_dur = val;
            CFG_AVG_CNT: avg_cnt = val[2:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] mn, input logic [15:0] mx,
                                  input logic [2:0] av);
        write_reg(CFG_MIN_DUR, mn);
        write_reg(CFG_MAX_DUR, mx);
        write_reg(CFG_AVG_CNT, {13'd0, av});
        settings_used++;
        @(negedge aclk);
    endtask

    // Mostly complete echo cycles with random content, some noise on top
    task automatic queue_random_phase(input int n_items);
        int          start_len;
        int          sel;
        logic [31:0] w;
        logic [31:0] t0;
        start_len = event_q.size();
        while (event_q.size() - start_len < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                case ($urandom_range(0, 4))
                    0: w = $urandom_range(0, 400);
                    1: w = {16'd0, min_dur} + 32'($urandom_range(0, 6)) - 32'd3;
                    2: w = $urandom_range(100, 30000);
                    3: w = $urandom_range(30000, 70000);
                    default: w = $urandom;
                endcase
                t0 = $urandom;
                push_event(KIND_EDGE, 1'b1, t0, 2'($urandom));
                // a trigger while the echo line is high gets refused
                if ($urandom_range(0, 3) == 0)
                    push_event(KIND_TRIGGER, 1'b1, $urandom, 2'($urandom));
                push_event(KIND_EDGE, 1'b0, t0 + w, 2'($urandom));
                if ($urandom_range(0, 4) != 0)
                    push_event(KIND_CHECK, 1'($urandom), $urandom, 2'($urandom));
                if ($urandom_range(0, 5) == 0)
                    push_event(KIND_CHECK, 1'($urandom), $urandom, 2'($urandom));
                if ($urandom_range(0, 2) == 0)
                    push_event(KIND_READ, 1'($urandom), $urandom, 2'($urandom));
                if ($urandom_range(0, 3) == 0)
                    push_event(KIND_TRIGGER, 1'b0, $urandom, 2'($urandom));
            end else if (sel < 80) begin
                repeat ($urandom_range(1, 4))
                    push_event(KIND_TRIGGER, 1'($urandom), $urandom, 2'($urandom));
            end else if (sel < 88) begin
                push_event(KIND_READ, 1'($urandom), $urandom, 2'($urandom));
            end else begin
                push_event(kind_t'($urandom_range(0, 3)), 1'($urandom), $urandom,
                           2'($urandom));
            end
        end
    endtask

    initial begin
        logic [15:0] mn;
        logic [15:0] mx;
        logic [2:0]  av;
        reset_predictor();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: read of reset slots, no data, refusal, fire, wrap-around widths
        push_event(KIND_READ,    1'b0, 32'd0,          2'd0);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd0);
        push_event(KIND_TRIGGER, 1'b1, 32'd0,          2'd3);
        push_event(KIND_TRIGGER, 1'b0, 32'hFFFF_FFFF,  2'd0);
        push_pulse(32'd100, 32'hFFFF_FFCE);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd0);
        push_pulse(32'd1000, 32'd50);
        push_event(KIND_CHECK,   1'b1, 32'hFFFF_FFFF,  2'd1);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd1);
        push_pulse(32'hFFFF_FFF0, 32'h0000_0110);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd3);
        push_event(KIND_READ,    1'b1, 32'hFFFF_FFFF,  2'd3);
        wait_idle();

        // Zero-width slot, full-range widths, count above the slot number
        apply_settings(16'd0, 16'hFFFF, 3'd7);
        push_pulse(32'd5, 32'd0);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd2);
        push_pulse(32'd0, 32'd65535);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd1);
        push_pulse(32'd0, 32'hFFFF_FFFF);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd0);
        push_event(KIND_READ,    1'b0, 32'd0,          2'd0);
        wait_idle();

        // Count of zero averages nothing
        apply_settings(16'd0, 16'hFFFF, 3'd0);
        push_event(KIND_READ,    1'b0, 32'd0,          2'd0);
        wait_idle();

        // Minimum above maximum: discard first, then clamp
        apply_settings(16'd1000, 16'd500, 3'd1);
        push_pulse(32'd0, 32'd700);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd0);
        push_pulse(32'd0, 32'd1200);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd0);
        push_event(KIND_READ,    1'b0, 32'd0,          2'd0);
        wait_idle();

        // No valid slot among the leading ones
        apply_settings(16'd0, 16'd1, 3'd1);
        push_pulse(32'd77, 32'd0);
        push_event(KIND_CHECK,   1'b0, 32'd0,          2'd0);
        push_event(KIND_READ,    1'b0, 32'd0,          2'd0);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            mn = (p == 1) ? 16'd0 : (p == 2) ? 16'hFFFF :
                 ($urandom_range(0, 1) ? 16'($urandom_range(50, 300)) : 16'($urandom));
            mx = (p == 3) ? 16'd1 : (p == 4) ? 16'hFFFF :
                 ($urandom_range(0, 1) ? 16'($urandom_range(20000, 30000))
                                       : 16'($urandom_range(1, 65535)));
            av = (p < 4) ? 3'(p + 1) : 3'($urandom_range(0, 7));
            apply_settings(mn, mx, av);
            if (p == 7) quiet = 1'b1;
            // stall the receiver long enough to back up the input
            if (p == 5) long_hold_mark = results_out + 12;
            if (p == 6) begin
                repeat (270) push_event(KIND_TRIGGER, 1'b1, $urandom, 2'($urandom));
                push_event(KIND_TRIGGER, 1'b0, $urandom, 2'($urandom));
            end
            queue_random_phase(165);
            wait_idle();
        end

        $display("Ran %0d events through %0d register settings, %0d results checked",
                 events_in, settings_used, results_out);
        if (err_count == 0 && result_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, result_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/uer_pkg.sv
design/uer_event.sv
design/uer_avg.sv
design/ultrasonic_echo_ranging.sv
design/uer_checker.sv
verif/tb_ultrasonic_echo_ranging.sv
